### design/rmst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants for the range-max segment tree unit.
// ----------------------------------------------------------------------------
package rmst_pkg;

  // default configuration
  localparam int unsigned LeavesDefault    = 1024;
  localparam int unsigned ValueBitsDefault = 40;

  // fixed field widths of the stream words
  localparam int unsigned IdxW    = 10;
  localparam int unsigned ValW    = 40;
  localparam int unsigned InDataW = 64;  // 10 + 10 + 40 = 60, padded to bytes
  localparam int unsigned OutDataW = 40;

endpackage
`default_nettype wire

### design/rmst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_ram
// Tree node store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
  parameter int unsigned Depth  = 2 * rmst_pkg::LeavesDefault,
  parameter int unsigned DataW  = rmst_pkg::ValueBitsDefault,
  parameter int unsigned AddrW  = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### design/range_max_segment_tree_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_max_segment_tree_unit
// Bottom-up segment tree keeping range maxima, with point update and query.
// ----------------------------------------------------------------------------
// Usage: each input word is an update (tuser = 0) or a range-max query
// (tuser = 1). An update writes one leaf (saturated to VALUE_BITS) and then
// walks up to the root, recomputing each parent from a single sibling read per
// level. It produces no output word. An update whose index is at or beyond
// LEAVES is dropped. A query walks the two range ends up the tree, one node
// read per cycle over the single read port of the node store, the low end and
// then the high end at each level. An empty range returns 0. The last index
// is clamped to LEAVES-1. The block takes one word at a time and stays not
// ready until the current one is done. After reset the node store is cleared
// by a pass over all 2*K nodes, K being LEAVES rounded up to a power of two,
// before the first word is accepted. The result sits in an output register,
// so the next word is accepted while a result still waits to be taken.
// ----------------------------------------------------------------------------
module range_max_segment_tree_unit #(
  parameter int unsigned LEAVES     = rmst_pkg::LeavesDefault,
  parameter int unsigned VALUE_BITS = rmst_pkg::ValueBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input words
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [9:0] first_index, [19:10] last_index, [59:20] new_value, [63:60] zero
  input  wire logic [rmst_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] req_type: 0 = update, 1 = query
  input  wire logic                          s_axis_tuser_i,
  // result words
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [39:0] range_max
  output logic [rmst_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned LvlW = $clog2(LEAVES);       // tree height
  localparam int unsigned K    = 1 << LvlW;            // leaf base
  localparam int unsigned NW   = LvlW + 1;             // node address bits
  localparam int unsigned AW   = NW + 1;               // walk pointers may reach 2K
  localparam int unsigned WW   = (VALUE_BITS > rmst_pkg::ValW) ? VALUE_BITS
                                                               : rmst_pkg::ValW;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_UPD  = 6'b000100,
    ST_QA   = 6'b001000,
    ST_QB   = 6'b010000,
    ST_QOUT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // input fields
  logic                          req_query;
  logic [rmst_pkg::IdxW-1:0]     lo_idx, hi_idx;
  logic [rmst_pkg::ValW-1:0]     new_val;

  assign req_query = s_axis_tuser_i;
  assign lo_idx    = s_axis_tdata_i[rmst_pkg::IdxW-1:0];
  assign hi_idx    = s_axis_tdata_i[2*rmst_pkg::IdxW-1:rmst_pkg::IdxW];
  assign new_val   = s_axis_tdata_i[2*rmst_pkg::IdxW+rmst_pkg::ValW-1:2*rmst_pkg::IdxW];

  // walk registers
  logic [NW-1:0]          clr_q, clr_d;
  logic [NW-1:0]          node_q, node_d;     // update: current node
  logic [VALUE_BITS-1:0]  cur_q, cur_d;       // update: value of current node
  logic [AW-1:0]          a_q, a_d, b_q, b_d; // query: range ends
  logic [VALUE_BITS-1:0]  best_q, best_d;
  logic                   pend_q, pend_d;     // read data to fold this cycle

  logic                   out_vld_q, out_vld_d;
  logic [rmst_pkg::OutDataW-1:0] out_dat_q, out_dat_d;

  // node store
  logic                   ram_we;
  logic [NW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0]  ram_wdata, ram_rdata;

  rmst_ram #(
    .Depth (2 * K),
    .DataW (VALUE_BITS),
    .AddrW (NW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // saturate incoming value to VALUE_BITS
  logic [WW-1:0]         val_w, vmax_w, sat_w;
  logic [VALUE_BITS-1:0] sat_val;
  assign val_w   = WW'(new_val);
  assign vmax_w  = WW'({VALUE_BITS{1'b1}});
  assign sat_w   = (val_w > vmax_w) ? vmax_w : val_w;
  assign sat_val = sat_w[VALUE_BITS-1:0];

  // index checks and clamp
  logic          lo_oob, hi_oob, range_empty;
  logic [AW-1:0] hi_clamp, leaf_lo, leaf_hi;
  assign lo_oob      = 32'(lo_idx) >= 32'(LEAVES);
  assign hi_oob      = 32'(hi_idx) >= 32'(LEAVES);
  assign hi_clamp    = hi_oob ? AW'(LEAVES - 1) : AW'(hi_idx);
  assign range_empty = 32'(lo_idx) > 32'(hi_clamp);
  assign leaf_lo     = AW'(K) + AW'(lo_idx);
  assign leaf_hi     = AW'(K) + hi_clamp;

  // shared compare unit: max of a register value and the read data
  logic [VALUE_BITS-1:0] cmp_a, cmp_max;
  assign cmp_a   = (state_q == ST_UPD) ? cur_q : best_q;
  assign cmp_max = (ram_rdata > cmp_a) ? ram_rdata : cmp_a;

  logic [VALUE_BITS-1:0] fold;
  assign fold = pend_q ? cmp_max : best_q;

  logic [NW-1:0] parent;
  logic [AW-1:0] b_dec;
  assign parent = node_q >> 1;
  assign b_dec  = b_q[0] ? b_q : b_q - AW'(1);

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready_i;

  logic [WW-1:0] best_w;
  assign best_w = WW'(best_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_dat_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    node_d    = node_q;
    cur_d     = cur_q;
    a_d       = a_q;
    b_d       = b_q;
    best_d    = best_q;
    pend_d    = 1'b0;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_dat_d = out_dat_q;
    ram_we    = 1'b0;
    ram_waddr = node_q;
    ram_wdata = cmp_max;
    ram_raddr = node_q ^ NW'(1);

    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + NW'(1);
        if (clr_q == {NW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (!req_query) begin
            if (!lo_oob) begin
              // write the leaf and fetch its sibling in the same cycle
              ram_we    = 1'b1;
              ram_waddr = leaf_lo[NW-1:0];
              ram_wdata = sat_val;
              ram_raddr = leaf_lo[NW-1:0] ^ NW'(1);
              node_d    = leaf_lo[NW-1:0];
              cur_d     = sat_val;
              state_d   = ST_UPD;
            end
          end else begin
            best_d = '0;
            a_d    = leaf_lo;
            b_d    = leaf_hi;
            if (range_empty) begin
              state_d = ST_QOUT;
            end else begin
              state_d = ST_QA;
            end
          end
        end
      end

      ST_UPD: begin
        // parent = max(node, sibling); fetch the parent's sibling meanwhile
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = cmp_max;
        ram_raddr = parent ^ NW'(1);
        cur_d     = cmp_max;
        node_d    = parent;
        if (parent == NW'(1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_QA: begin
        best_d = fold;
        if (a_q > b_q) begin
          state_d = ST_QOUT;
        end else begin
          ram_raddr = a_q[NW-1:0];
          if (a_q[0]) begin
            pend_d = 1'b1;
            a_d    = a_q + AW'(1);
          end
          state_d = ST_QB;
        end
      end

      ST_QB: begin
        best_d    = fold;
        ram_raddr = b_q[NW-1:0];
        pend_d    = !b_q[0];
        a_d       = a_q >> 1;
        b_d       = b_dec >> 1;
        state_d   = ST_QA;
      end

      ST_QOUT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_dat_d = best_w[rmst_pkg::OutDataW-1:0];
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    cur_q     <= cur_d;
    a_q       <= a_d;
    b_q       <= b_d;
    best_q    <= best_d;
    out_dat_q <= out_dat_d;
  end

endmodule
`default_nettype wire

### tb/sv/range_max_segment_tree_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_max_segment_tree_unit_test
// Self-checking bench for the range-max segment tree unit.
// ----------------------------------------------------------------------------
// Drives update and query words over the input stream. A local copy of the
// tree predicts each query result, and the results are checked in order.
// Phases: directed corners, random traffic with idle bursts on both sides, a
// long output hold that backs up the input, a drain pause, and a steady
// stream with no idling.
// ----------------------------------------------------------------------------
module range_max_segment_tree_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEAF_COUNT  = rmst_pkg::LeavesDefault;  // power of two
  localparam int unsigned IDX_W       = rmst_pkg::IdxW;
  localparam int unsigned VAL_W       = rmst_pkg::ValW;
  localparam int unsigned PAD_W       = rmst_pkg::InDataW - 2 * IDX_W - VAL_W;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef enum logic {
    REQ_UPDATE = 1'b0,
    REQ_QUERY  = 1'b1
  } req_kind_e;

  typedef logic [IDX_W-1:0] leaf_idx_t;
  typedef logic [VAL_W-1:0] node_val_t;

  logic                        clk_i    = 1'b0;
  logic                        rst_ni   = 1'b0;
  logic                        s_tvalid = 1'b0;
  logic                        s_tuser  = 1'b0;
  logic [rmst_pkg::InDataW-1:0] s_tdata = '0;
  logic                        m_tready = 1'b0;
  wire logic                   s_axis_tready_o;
  wire logic                   m_axis_tvalid_o;
  wire logic [rmst_pkg::OutDataW-1:0] m_axis_tdata_o;

  range_max_segment_tree_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted tree: node n has children 2n and 2n+1, leaves at LEAF_COUNT + i.
  node_val_t peak_tree [1:2*LEAF_COUNT-1];
  node_val_t peak_expect_q [$];

  bit          idle_on       = 1'b1;
  int unsigned hold_asked    = 0;   // bumped by a test to request a long hold
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned updates_sent  = 0;
  int unsigned queries_sent  = 0;
  int unsigned empty_queries = 0;
  int unsigned results_seen  = 0;

  // ---------------------------------------------------------------- predictor
  task automatic tree_write(input leaf_idx_t leaf, input node_val_t value);
    int unsigned node;
    node = leaf + LEAF_COUNT;
    peak_tree[node] = value;
    node = node >> 1;
    while (node != 0) begin
      peak_tree[node] = (peak_tree[2*node] > peak_tree[2*node+1]) ?
                        peak_tree[2*node] : peak_tree[2*node+1];
      node = node >> 1;
    end
  endtask

  function automatic node_val_t tree_peak(input leaf_idx_t lo, input leaf_idx_t hi);
    int unsigned a;
    int unsigned b;
    node_val_t   best;
    best = '0;
    if (lo <= hi) begin
      a = lo + LEAF_COUNT;
      b = hi + LEAF_COUNT;
      while (a <= b) begin
        if (a[0]) begin
          if (peak_tree[a] > best) best = peak_tree[a];
          a++;
        end
        if (!b[0]) begin
          if (peak_tree[b] > best) best = peak_tree[b];
          b--;
        end
        a = a >> 1;
        b = b >> 1;
      end
    end
    return best;
  endfunction

  // ---------------------------------------------------------------- sender
  // Valid stays high between back-to-back words; in this task it only drops for a gap.
  task automatic send_word(input req_kind_e kind, input leaf_idx_t first,
                           input leaf_idx_t last, input node_val_t value);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{PAD_W{1'b0}}, value, last, first};
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    if (kind == REQ_UPDATE) begin
      if (first < LEAF_COUNT) tree_write(first, value);
      updates_sent++;
    end else begin
      if (first > last) empty_queries++;
      peak_expect_q.push_back(tree_peak(first, last));
      queries_sent++;
    end
  endtask

  task automatic wait_results_drained();
    while (peak_expect_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic node_val_t pick_value();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2:       return node_val_t'(raw[7:0]);
      default: return raw[VAL_W-1:0];
    endcase
  endfunction

  task automatic send_random_word();
    leaf_idx_t lo;
    leaf_idx_t hi;
    lo = leaf_idx_t'($urandom_range(0, LEAF_COUNT - 1));
    if ($urandom_range(0, 99) < 45) begin
      send_word(REQ_UPDATE, lo, leaf_idx_t'($urandom()), pick_value());
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: hi = (lo + 15 > LEAF_COUNT - 1) ? leaf_idx_t'(LEAF_COUNT - 1) :
                         leaf_idx_t'(lo + $urandom_range(0, 15));
        4, 5, 6:    hi = leaf_idx_t'($urandom_range(lo, LEAF_COUNT - 1));
        7: begin    // empty range, low end above high end
          if (lo == 0) lo = 1;
          hi = leaf_idx_t'($urandom_range(0, lo - 1));
        end
        8: begin
          lo = 0;
          hi = leaf_idx_t'($urandom_range(0, LEAF_COUNT - 1));
        end
        default:    hi = leaf_idx_t'(LEAF_COUNT - 1);
      endcase
      send_word(REQ_QUERY, lo, hi, pick_value());
    end
  endtask

  // ---------------------------------------------------------------- receiver
  // Random stall bursts, plus a long hold whenever a test bumps hold_asked.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      results_seen++;
      if (peak_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t: result word with no query pending: expected none actual %h",
                 $time, m_axis_tdata_o);
      end else begin
        if (m_axis_tdata_o !== peak_expect_q[0]) begin
          mismatches++;
          $display("%0t: range_max mismatch: expected %h actual %h",
                   $time, peak_expect_q[0], m_axis_tdata_o);
        end
        void'(peak_expect_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) cycle_count++;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timed out with %0d results outstanding", $time, peak_expect_q.size());
    $display("[range_max_segment_tree_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- tests
  // Empty tree, both ends of the leaf array, extreme values, empty ranges,
  // overwrite of the current maximum, update with a stray last index.
  task automatic test_directed_corners();
    send_word(REQ_QUERY,  10'd0,    10'd1023, '0);
    send_word(REQ_UPDATE, 10'd0,    10'd1023, '1);
    send_word(REQ_UPDATE, 10'd1023, 10'd0,    40'd1);
    send_word(REQ_UPDATE, 10'd511,  10'h155,  40'h55_5555_5555);
    send_word(REQ_UPDATE, 10'd512,  10'h2AA,  40'hAA_AAAA_AAAA);
    send_word(REQ_QUERY,  10'd0,    10'd1023, '1);
    send_word(REQ_QUERY,  10'd0,    10'd0,    '0);
    send_word(REQ_QUERY,  10'd1023, 10'd1023, '0);
    send_word(REQ_QUERY,  10'd1023, 10'd0,    '0);
    send_word(REQ_QUERY,  10'd5,    10'd4,    '0);
    send_word(REQ_QUERY,  10'd1,    10'd1022, '0);
    send_word(REQ_QUERY,  10'd511,  10'd511,  '0);
    send_word(REQ_QUERY,  10'd511,  10'd512,  '0);
    send_word(REQ_UPDATE, 10'd0,    10'd0,    '0);
    send_word(REQ_QUERY,  10'd0,    10'd1023, '0);
    send_word(REQ_QUERY,  10'd0,    10'd511,  '0);
    send_word(REQ_QUERY,  10'd513,  10'd1023, '0);
    send_word(REQ_UPDATE, 10'd1023, 10'd1023, '1);
    send_word(REQ_QUERY,  10'd1022, 10'd1023, '0);
    send_word(REQ_QUERY,  10'd2,    10'd1,    '0);
  endtask

  task automatic test_random_mix(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random_word();
    end
    idle_on = 1'b1;
  endtask

  // Long receiver hold while queries keep coming, so the input stalls.
  task automatic test_output_hold();
    hold_asked <= hold_asked + 1;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) send_random_word();
      else send_word(REQ_QUERY, leaf_idx_t'($urandom_range(0, 511)),
                     leaf_idx_t'($urandom_range(512, LEAF_COUNT - 1)), '0);
    end
  endtask

  // Sender goes quiet until every pending result has come back.
  task automatic test_drain_pause();
    for (int i = 0; i < 30; i++) send_random_word();
    s_tvalid <= 1'b0;
    wait_results_drained();
    for (int i = 0; i < 30; i++) send_random_word();
  endtask

  task automatic test_steady_stream(input int unsigned count);
    idle_on = 1'b0;
    for (int unsigned i = 0; i < count; i++) send_random_word();
  endtask

  initial begin : main
    foreach (peak_tree[n]) peak_tree[n] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_random_mix(1100);
    test_output_hold();
    test_drain_pause();
    test_steady_stream(330);

    s_tvalid <= 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d updates and %0d queries (%0d empty ranges), %0d results checked",
             updates_sent, queries_sent, empty_queries, results_seen);
    $display("phases: corners, random mix, output hold, drain pause, steady stream; %0d cycles",
             cycle_count);
    if (mismatches == 0 && peak_expect_q.size() == 0) begin
      $display("[range_max_segment_tree_unit] OK");
    end else begin
      $display("[range_max_segment_tree_unit] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
design/rmst_pkg.sv
design/rmst_ram.sv
design/range_max_segment_tree_unit.sv
tb/sv/range_max_segment_tree_unit_test.sv
